// ===== sv/assert_macros.svh =====
// assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/b64d_pkg.sv =====
`timescale 1ns / 1ps

package b64d_pkg;

    // symbol codes beyond the 64 alphabet values
    localparam logic [6:0] SYM_SKIP    = 7'd64;
    localparam logic [6:0] SYM_PAD     = 7'd65;
    localparam logic [6:0] SYM_INVALID = 7'd66;

    // status codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_INVALID  = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    localparam logic [23:0] CAP_RESET = 24'hFFFFFF;

    typedef struct packed {
        logic [7:0] enc_char;
        logic       final_char;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_status;
        logic [1:0]  status;
        logic [23:0] total_len;
        logic        run_last;
    } t_out_item;

    // all results caused by one character: up to three data bytes and a status
    typedef struct packed {
        logic [1:0]      cnt;
        logic            stat;
        logic [1:0]      status;
        logic [23:0]     total_len;
        logic [2:0][7:0] bytes;
    } t_bundle;

    // standard alphabet lookup
    function automatic logic [6:0] classify(input logic [7:0] c);
        logic [7:0] v;
        v = {1'b0, SYM_INVALID};
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = c - 8'd65;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'd71;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c + 8'd4;
        end else if (c == 8'h2B) begin
            v = 8'd62;
        end else if (c == 8'h2F) begin
            v = 8'd63;
        end else if (c == 8'h0A) begin
            v = {1'b0, SYM_SKIP};
        end else if (c == 8'h3D) begin
            v = {1'b0, SYM_PAD};
        end
        return v[6:0];
    endfunction

endpackage

// ===== sv/base64_decoder.sv =====
`timescale 1ns / 1ps

// Streaming base64 decoder, standard alphabet: one encoded character per
// transfer, final_char closing the message with a status result that carries
// the error code and the decoded length. Characters that yield no result
// pass straight through the decode stage; one that completes a group of four,
// or the final one, occupies the result register until its results (up to
// four: three bytes and the status) have been sent. A character is taken
// every cycle but when the next result-bearing one reaches the decode stage
// before that register has drained: then the input stalls. Four characters
// give three bytes, so a steady stream runs at one character per cycle while
// the result side is ready. The user must write max_output_bytes (i_cfg_data)
// only between messages or while the block is idle; this is not enforced.
module base64_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  b64d_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output b64d_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [23:0]         i_cfg_data
);

    logic               r_in_vld;
    b64d_pkg::t_in_item r_in;
    logic [23:0]        r_max;

    b64d_pkg::t_bundle bnd;
    logic              bnd_empty;
    logic              out_free;
    logic              adv;

    // decode stage advances when its results have somewhere to go
    assign bnd_empty  = (bnd.cnt == 2'd0) && !bnd.stat;
    assign adv        = r_in_vld && (bnd_empty || out_free);
    assign o_in_ready = !r_in_vld || adv;
    assign o_cfg_ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= b64d_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_data;
        end
    end

    b64d_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in),
        .i_max   (r_max),
        .o_bnd   (bnd)
    );

    b64d_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (adv && !bnd_empty),
        .i_bnd       (bnd),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sv/b64d_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64d_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  b64d_pkg::t_in_item i_item,
    input  logic [23:0]        i_max,
    output b64d_pkg::t_bundle  o_bnd
);

    logic [1:0]  r_sym;
    logic [23:0] r_acc;
    logic [23:0] r_bw;
    logic        r_pad;
    logic [1:0]  r_err;

    logic [1:0]  n_sym;
    logic [23:0] n_acc;
    logic [23:0] n_bw;
    logic        n_pad;
    logic [1:0]  n_err;

    logic [6:0]      code;
    logic [23:0]     acc_sh;
    logic [1:0]      sym_mid;
    logic [23:0]     acc_mid;
    logic            pad_mid;
    logic [1:0]      err_mid;
    logic [1:0]      err_out;
    logic [23:0]     bw_out;
    logic [1:0]      need;
    logic [1:0]      kept;
    logic [2:0]      fits;
    logic [2:0][7:0] bytes;

    // symbol decode and accumulator shift
    always_comb begin
        code    = b64d_pkg::classify(i_item.enc_char);
        acc_sh  = {r_acc[17:0], code[5:0]};
        sym_mid = r_sym;
        acc_mid = r_acc;
        pad_mid = r_pad;
        err_mid = r_err;
        need    = 2'd0;
        bytes   = '0;
        if (r_err == b64d_pkg::ERR_NONE && !r_pad) begin
            if (code == b64d_pkg::SYM_INVALID) begin
                err_mid = b64d_pkg::ERR_INVALID;
            end else if (code == b64d_pkg::SYM_PAD) begin
                pad_mid = 1'b1;
            end else if (code != b64d_pkg::SYM_SKIP) begin
                acc_mid = acc_sh;
                sym_mid = r_sym + 2'd1;
            end
        end
        // full group or tail on the final character
        if (r_err == b64d_pkg::ERR_NONE && !r_pad && !code[6] && r_sym == 2'd3) begin
            need    = 2'd3;
            bytes   = {acc_sh[7:0], acc_sh[15:8], acc_sh[23:16]};
            acc_mid = '0;
        end else if (i_item.final_char && err_mid == b64d_pkg::ERR_NONE) begin
            if (sym_mid == 2'd3) begin
                need  = 2'd2;
                bytes = {8'd0, acc_mid[9:2], acc_mid[17:10]};
            end else if (sym_mid == 2'd2) begin
                need  = 2'd1;
                bytes = {8'd0, 8'd0, acc_mid[11:4]};
            end
        end
    end

    // capacity check byte by byte
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fits[i] = ({1'b0, r_bw} + 25'(i)) < {1'b0, i_max};
        end
        kept = need;
        if (need != 2'd0 && !fits[0]) begin
            kept = 2'd0;
        end else if (need >= 2'd2 && !fits[1]) begin
            kept = 2'd1;
        end else if (need == 2'd3 && !fits[2]) begin
            kept = 2'd2;
        end
        err_out = err_mid;
        if (kept != need) begin
            err_out = b64d_pkg::ERR_OVERFLOW;
        end
        bw_out = r_bw + {22'd0, kept};
    end

    // result bundle
    always_comb begin
        o_bnd.cnt       = kept;
        o_bnd.stat      = i_item.final_char;
        o_bnd.status    = err_out;
        o_bnd.total_len = bw_out;
        o_bnd.bytes     = bytes;
    end

    // next state, cleared after the final character
    always_comb begin
        n_sym = sym_mid;
        n_acc = acc_mid;
        n_pad = pad_mid;
        n_err = err_out;
        n_bw  = bw_out;
        if (i_item.final_char) begin
            n_sym = '0;
            n_acc = '0;
            n_pad = 1'b0;
            n_err = b64d_pkg::ERR_NONE;
            n_bw  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym <= '0;
            r_acc <= '0;
            r_bw  <= '0;
            r_pad <= 1'b0;
            r_err <= b64d_pkg::ERR_NONE;
        end else if (i_adv) begin
            r_sym <= n_sym;
            r_acc <= n_acc;
            r_bw  <= n_bw;
            r_pad <= n_pad;
            r_err <= n_err;
        end
    end

    // message state starts fresh after the final character
    `ASSERT_NEXT(a_clear_after_final, i_clk, i_rst_n, i_adv && i_item.final_char, r_sym == 2'd0 && r_bw == 24'd0 && r_err == b64d_pkg::ERR_NONE && !r_pad, "state not cleared after final")
    // a latched error is kept until the message ends
    `ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, i_adv && !i_item.final_char && r_err != b64d_pkg::ERR_NONE, r_err == $past(r_err), "latched error changed")

endmodule

// ===== sv/b64d_out.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64d_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  b64d_pkg::t_bundle   i_bnd,
    output logic                o_free,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output b64d_pkg::t_out_item o_out_data
);

    logic              r_vld;
    logic [1:0]        r_idx;
    b64d_pkg::t_bundle r_bnd;

    logic at_stat;
    logic last;

    // current result of the held bundle
    always_comb begin
        at_stat = (r_idx == r_bnd.cnt);
        last    = r_bnd.stat ? at_stat : (r_idx == r_bnd.cnt - 2'd1);
        o_out_data.is_status = at_stat;
        o_out_data.run_last  = last;
        if (at_stat) begin
            o_out_data.out_byte  = 8'd0;
            o_out_data.status    = r_bnd.status;
            o_out_data.total_len = r_bnd.total_len;
        end else begin
            o_out_data.status    = b64d_pkg::ERR_NONE;
            o_out_data.total_len = 24'd0;
            case (r_idx)
                2'd0:    o_out_data.out_byte = r_bnd.bytes[0];
                2'd1:    o_out_data.out_byte = r_bnd.bytes[1];
                default: o_out_data.out_byte = r_bnd.bytes[2];
            endcase
        end
    end

    assign o_out_valid = r_vld;
    assign o_free      = !r_vld || (i_out_ready && last);

    // control: step through the bundle one transfer at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (i_load) begin
            r_vld <= 1'b1;
            r_idx <= '0;
        end else if (r_vld && i_out_ready) begin
            if (last) begin
                r_vld <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bnd <= i_bnd;
        end
    end

    `ASSERT_IMPL(a_no_empty_bundle, i_clk, i_rst_n, r_vld, r_bnd.cnt != 2'd0 || r_bnd.stat, "empty bundle held")
    `ASSERT_IMPL(a_idx_in_range, i_clk, i_rst_n, r_vld, r_idx <= r_bnd.cnt, "result index past bundle")

endmodule

// ===== verif/base64_decoder_test.sv =====
`timescale 1ns / 1ps

module base64_decoder_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_CHARS   = 360;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_PAD = 8'h3D;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    b64d_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    b64d_pkg::t_out_item o_out_data;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [23:0]         i_cfg_data;

    base64_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // decoder state mirrored for prediction
    logic [1:0]  pr_sym_cnt;
    logic [23:0] pr_acc;
    logic [23:0] pr_nbytes;
    logic        pr_pad_seen;
    logic [1:0]  pr_err;
    logic [23:0] pr_capacity;

    b64d_pkg::t_out_item decoded_fifo[$];
    int                  n_fail;
    int                  n_chars;
    bit                  idle_on;
    int                  quiet_cycles;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // alphabet value of a character, or a skip, pad or invalid code
    function automatic logic [6:0] symbol_of(input logic [7:0] c);
        logic [7:0] d;
        if (c >= "A" && c <= "Z") begin
            d = c - "A";
            return {1'b0, d[5:0]};
        end
        if (c >= "a" && c <= "z") begin
            d = c - "a" + 8'd26;
            return {1'b0, d[5:0]};
        end
        if (c >= "0" && c <= "9") begin
            d = c - "0" + 8'd52;
            return {1'b0, d[5:0]};
        end
        if (c == "+") return 7'd62;
        if (c == "/") return 7'd63;
        if (c == CH_LF) return b64d_pkg::SYM_SKIP;
        if (c == CH_PAD) return b64d_pkg::SYM_PAD;
        return b64d_pkg::SYM_INVALID;
    endfunction

    // character for an alphabet index
    function automatic logic [7:0] alpha_char(input int idx);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        if (idx == 62) return "+";
        return "/";
    endfunction

    function automatic void clear_message_state();
        pr_sym_cnt  = '0;
        pr_acc      = '0;
        pr_nbytes   = '0;
        pr_pad_seen = 1'b0;
        pr_err      = b64d_pkg::ERR_NONE;
    endfunction

    // one data byte, held back once an error is latched or capacity is reached
    function automatic void push_data_byte(input logic [7:0] b);
        b64d_pkg::t_out_item r;
        if (pr_err != b64d_pkg::ERR_NONE) return;
        if (pr_nbytes >= pr_capacity) begin
            pr_err = b64d_pkg::ERR_OVERFLOW;
            return;
        end
        pr_nbytes = pr_nbytes + 24'd1;
        r = '0;
        r.out_byte = b;
        decoded_fifo.push_back(r);
    endfunction

    // expected results of one accepted character
    function automatic void predict_decode(input b64d_pkg::t_in_item it);
        logic [6:0]          v;
        b64d_pkg::t_out_item r;
        int                  n_before;
        n_before = decoded_fifo.size();
        if (pr_err == b64d_pkg::ERR_NONE && !pr_pad_seen) begin
            v = symbol_of(it.enc_char);
            if (v == b64d_pkg::SYM_INVALID) begin
                pr_err = b64d_pkg::ERR_INVALID;
            end else if (v == b64d_pkg::SYM_PAD) begin
                pr_pad_seen = 1'b1;
            end else if (v != b64d_pkg::SYM_SKIP) begin
                pr_acc = {pr_acc[17:0], v[5:0]};
                pr_sym_cnt = pr_sym_cnt + 2'd1;
                if (pr_sym_cnt == 2'd0) begin
                    push_data_byte(pr_acc[23:16]);
                    push_data_byte(pr_acc[15:8]);
                    push_data_byte(pr_acc[7:0]);
                    pr_acc = '0;
                end
            end
        end
        if (it.final_char) begin
            // flush the partial group, then the status closes the message
            if (pr_err == b64d_pkg::ERR_NONE) begin
                if (pr_sym_cnt == 2'd3) begin
                    push_data_byte(pr_acc[17:10]);
                    push_data_byte(pr_acc[9:2]);
                end else if (pr_sym_cnt == 2'd2) begin
                    push_data_byte(pr_acc[11:4]);
                end
            end
            r = '0;
            r.is_status = 1'b1;
            r.status    = pr_err;
            r.total_len = pr_nbytes;
            decoded_fifo.push_back(r);
            clear_message_state();
        end
        if (decoded_fifo.size() > n_before) begin
            r = decoded_fifo.pop_back();
            r.run_last = 1'b1;
            decoded_fifo.push_back(r);
        end
    endfunction

    // one character transfer, with a random lead-in gap while idling is on
    task automatic send_char(input logic [7:0] c, input logic fin);
        int                 gap;
        b64d_pkg::t_in_item it;
        it.enc_char   = c;
        it.final_char = fin;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_decode(it);
        n_chars++;
    endtask

    // text as one message, final flag on its last character
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    // stop sending and wait for every expected result plus settling time
    task automatic drain_outputs();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (decoded_fifo.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // capacity register write, only while idle
    task automatic write_capacity(input logic [23:0] cap);
        drain_outputs();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        pr_capacity = cap;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random message: alphabet symbols with line feeds, padding and optional noise
    task automatic send_random_message(input int n_sym, input bit noisy);
        b64d_pkg::t_in_item msg[$];
        b64d_pkg::t_in_item it;
        int                 pads;
        it.final_char = 1'b0;
        for (int k = 0; k < n_sym; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                it.enc_char = CH_LF;
                msg.push_back(it);
            end
            it.enc_char = alpha_char($urandom_range(0, 63));
            msg.push_back(it);
            if (noisy && $urandom_range(0, 5) == 0) begin
                it.enc_char = 8'($urandom_range(0, 255));
                msg.push_back(it);
            end
        end
        case (n_sym % 4)
            2:       pads = $urandom_range(0, 2);
            3:       pads = $urandom_range(0, 1);
            default: pads = noisy ? $urandom_range(0, 2) : 0;
        endcase
        for (int k = 0; k < pads; k++) begin
            it.enc_char = CH_PAD;
            msg.push_back(it);
        end
        // trailing random byte, ignored after padding and decoded like any other byte otherwise
        if ($urandom_range(0, 3) == 0) begin
            it.enc_char = 8'($urandom_range(0, 255));
            msg.push_back(it);
        end
        foreach (msg[i]) begin
            msg[i].final_char = (i == msg.size() - 1) ||
                                (noisy && $urandom_range(0, 15) == 0);
            send_char(msg[i].enc_char, msg[i].final_char);
        end
    endtask

    // alphabet extremes, skip, padding, tails and invalid bytes
    task automatic test_directed();
        idle_on = 1'b1;
        send_text("AZaz09+/");
        send_char("Q", 1'b0);
        send_char(CH_LF, 1'b0);
        send_char("Q", 1'b0);
        send_char(CH_PAD, 1'b0);
        send_char(8'hFF, 1'b1);
        send_text("QUJ");
        send_char("Q", 1'b0);
        send_char(CH_LF, 1'b1);
        send_char(8'h00, 1'b0);
        send_char("A", 1'b0);
        send_char(8'h80, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char(CH_PAD, 1'b1);
    endtask

    // capacity limits: zero, exact fit, partial groups and partial tails
    task automatic test_capacity();
        write_capacity(24'd0);
        send_text("TWFu");
        write_capacity(24'd4);
        send_text("TWFuTWFu");
        write_capacity(24'd2);
        send_text("TWE");
        write_capacity(24'd1);
        send_text("TWE");
        send_char(8'h21, 1'b1);
        write_capacity(24'hFFFFFE);
        send_text("TWFuTWE=");
        write_capacity(b64d_pkg::CAP_RESET);
    endtask

    // random messages under changing capacity and idling
    task automatic test_random_stream();
        int msg_no;
        logic [23:0] cap;
        msg_no = 0;
        while (n_chars < RANDOM_CHARS + 25) begin
            if (msg_no % 6 == 5) begin
                case ($urandom_range(0, 4))
                    0:       cap = 24'd0;
                    1:       cap = 24'($urandom_range(1, 12));
                    2:       cap = 24'($urandom_range(13, 24'hFFFFFE));
                    default: cap = b64d_pkg::CAP_RESET;
                endcase
                write_capacity(cap);
            end
            idle_on = (msg_no % 5 != 4);
            send_random_message($urandom_range(1, 12), $urandom_range(0, 4) == 0);
            msg_no++;
        end
    endtask

    // result side ready with random stalls
    initial begin
        i_out_ready = 1'b0;
        forever begin
            int stall;
            @(negedge i_clk);
            stall = idle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        b64d_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (decoded_fifo.size() == 0) begin
                n_fail++;
                if (n_fail <= REPORT_LIMIT) begin
                    $display("unexpected result: byte=%h stat=%b status=%0d len=%0d last=%b",
                             o_out_data.out_byte, o_out_data.is_status,
                             o_out_data.status, o_out_data.total_len,
                             o_out_data.run_last);
                end
            end else begin
                want = decoded_fifo.pop_front();
                if (o_out_data !== want) begin
                    n_fail++;
                    if (n_fail <= REPORT_LIMIT) begin
                        $display("mismatch exp: byte=%h stat=%b status=%0d len=%0d last=%b",
                                 want.out_byte, want.is_status, want.status,
                                 want.total_len, want.run_last);
                        $display("         got: byte=%h stat=%b status=%0d len=%0d last=%b",
                                 o_out_data.out_byte, o_out_data.is_status,
                                 o_out_data.status, o_out_data.total_len,
                                 o_out_data.run_last);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // test sequence
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        n_fail       = 0;
        n_chars      = 0;
        idle_on      = 1'b1;
        quiet_cycles = 0;
        pr_capacity  = b64d_pkg::CAP_RESET;
        clear_message_state();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_capacity();
        test_random_stream();
        drain_outputs();

        if (n_fail == 0 && decoded_fifo.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
